// File: hdl/fatlb_pkg.sv
// Shared types and sizing constants for the fully associative TLB.
// No dependencies; used by every module under hdl/ except fatlb_ram.
package fatlb_pkg;

    localparam int ENTRIES    = 256;
    localparam int PAGE_BITS  = 8;
    localparam int FRAME_BITS = 7;

    // Entry index and scan counter (the counter also holds ENTRIES itself).
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // One RAM word: page in the upper bits, frame in the lower bits.
    localparam int WORD_W = PAGE_BITS + FRAME_BITS;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = ((PAGE_BITS + FRAME_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FRAME_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_INVAL  = 2'd2,
        REQ_FLUSH  = 2'd3
    } req_e_t;

    typedef struct packed {
        req_e_t                 req_type;
        logic [PAGE_BITS-1:0]   page_number;
        logic [FRAME_BITS-1:0]  frame_number;
    } req_t;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_BITS-1:0]  found_frame;
        logic                   full_res;
    } res_t;

endpackage

// File: hdl/fatlb_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fatlb_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 15
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/fatlb_seq.sv
// Scan sequencer: valid bits, the shared entry compare unit and the entry RAM.
// Depends on fatlb_pkg and fatlb_ram.
module fatlb_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  fatlb_pkg::req_t   req,
    output logic              res_valid,
    input  logic              res_ready,
    output fatlb_pkg::res_t   res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                             state_reg, state_next;
    fatlb_pkg::req_t                    req_reg, req_next;
    fatlb_pkg::res_t                    res_reg, res_next;
    logic [fatlb_pkg::CNT_W-1:0]        addr_reg, addr_next;
    logic                               cmp_live_reg, cmp_live_next;
    logic [fatlb_pkg::IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [fatlb_pkg::ENTRIES-1:0]      valid_reg, valid_next;

    logic                               wr_en;
    logic [fatlb_pkg::WORD_W-1:0]       rd_word;
    logic [fatlb_pkg::PAGE_BITS-1:0]    rd_page;
    logic [fatlb_pkg::FRAME_BITS-1:0]   rd_frame;
    logic                               ent_valid;
    logic                               match;
    logic                               last_entry;

    fatlb_ram #(
        .DEPTH (fatlb_pkg::ENTRIES),
        .WIDTH (fatlb_pkg::WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cmp_idx_reg),
        .wr_data ({req_reg.page_number, req_reg.frame_number}),
        .rd_addr (addr_reg[fatlb_pkg::IDX_W-1:0]),
        .rd_data (rd_word)
    );

    assign rd_page    = rd_word[fatlb_pkg::WORD_W-1 -: fatlb_pkg::PAGE_BITS];
    assign rd_frame   = rd_word[fatlb_pkg::FRAME_BITS-1:0];
    assign ent_valid  = valid_reg[cmp_idx_reg];
    assign last_entry = (cmp_idx_reg == fatlb_pkg::IDX_W'(fatlb_pkg::ENTRIES - 1));

    // Shared compare unit: one entry per cycle against the current request.
    always_comb begin
        case (req_reg.req_type)
            fatlb_pkg::REQ_LOOKUP: match = ent_valid && (rd_page == req_reg.page_number);
            fatlb_pkg::REQ_INSERT: match = !ent_valid;
            fatlb_pkg::REQ_INVAL:  match = ent_valid && (rd_frame == req_reg.frame_number);
            default:               match = 1'b0;
        endcase
    end

    assign wr_en = (state_reg == ST_SCAN) && cmp_live_reg && match &&
                   (req_reg.req_type == fatlb_pkg::REQ_INSERT);

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        addr_next     = addr_reg;
        cmp_live_next = cmp_live_reg;
        cmp_idx_next  = cmp_idx_reg;
        valid_next    = valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    req_next      = req;
                    res_next      = '0;
                    addr_next     = '0;
                    cmp_live_next = 1'b0;
                    if (req.req_type == fatlb_pkg::REQ_FLUSH) begin
                        valid_next = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cmp_live_reg && match) begin
                    cmp_live_next = 1'b0;
                    state_next    = ST_DONE;
                    case (req_reg.req_type)
                        fatlb_pkg::REQ_LOOKUP: begin
                            res_next.hit         = 1'b1;
                            res_next.found_frame = rd_frame;
                        end
                        fatlb_pkg::REQ_INSERT: valid_next[cmp_idx_reg] = 1'b1;
                        fatlb_pkg::REQ_INVAL:  valid_next[cmp_idx_reg] = 1'b0;
                        default: ;
                    endcase
                end else if (cmp_live_reg && last_entry) begin
                    // Scanned everything without a match.
                    cmp_live_next     = 1'b0;
                    state_next        = ST_DONE;
                    res_next.full_res = (req_reg.req_type == fatlb_pkg::REQ_INSERT);
                end else if (addr_reg < fatlb_pkg::CNT_W'(fatlb_pkg::ENTRIES)) begin
                    cmp_live_next = 1'b1;
                    cmp_idx_next  = addr_reg[fatlb_pkg::IDX_W-1:0];
                    addr_next     = addr_reg + 1'b1;
                end else begin
                    cmp_live_next = 1'b0;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cmp_live_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            cmp_live_reg <= cmp_live_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        addr_reg    <= addr_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

// File: hdl/fully_associative_tlb.sv
// Top level of the fully associative TLB: stream ports and result register.
// Depends on fatlb_pkg, fatlb_seq (which holds fatlb_ram).
//
//  channel | dir | handshake          | payload (lowest bit first)
//  --------+-----+--------------------+--------------------------------------------
//  request | in  | s_tvalid/s_tready  | tdata: page_number[7:0], frame_number[14:8]
//          |     |                    | tuser: req_type[1:0]
//  result  | out | m_tvalid/m_tready  | tdata: found_frame[6:0]; tuser: hit, full_res
//
// Lookup, insert and invalidate scan the entries in index order, one entry per
// cycle through a single compare unit fed by the entry RAM's read port (a match
// stops the scan early). Flush clears all valid flops at once, with no scan.
// Reset clears all valid bits at once; no clearing pass is needed.
// s_tready is low while a request is in progress or its result waits to be
// handed to the output register; a stalled m_tready holds the scan result.
module fully_associative_tlb (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fatlb_pkg::S_TDATA_W-1:0]    s_tdata,  // page_number, frame_number, pad
    input  logic [fatlb_pkg::S_TUSER_W-1:0]    s_tuser,  // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fatlb_pkg::M_TDATA_W-1:0]    m_tdata,  // found_frame, pad
    output logic [fatlb_pkg::M_TUSER_W-1:0]    m_tuser   // hit, full_res
);

    fatlb_pkg::req_t   req;
    fatlb_pkg::res_t   seq_res;
    logic              seq_res_valid;
    logic              seq_res_ready;

    fatlb_pkg::res_t   out_res_reg, out_res_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Unpack the request.
    assign req.req_type     = fatlb_pkg::req_e_t'(s_tuser);
    assign req.page_number  = s_tdata[fatlb_pkg::PAGE_BITS-1:0];
    assign req.frame_number = s_tdata[fatlb_pkg::PAGE_BITS +: fatlb_pkg::FRAME_BITS];

    fatlb_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res)
    );

    // Output register: takes a new result when empty or being drained.
    assign seq_res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_res_next  = out_res_reg;
        if (seq_res_ready) begin
            m_tvalid_next = seq_res_valid;
            if (seq_res_valid) begin
                out_res_next = seq_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = fatlb_pkg::M_TDATA_W'(out_res_reg.found_frame);
    assign m_tuser[0] = out_res_reg.hit;
    assign m_tuser[1] = out_res_reg.full_res;

`ifndef SYNTHESIS
    // An accepted request leaves idle, so the block cannot take another right after.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in progress");

    // An insert result never carries lookup fields.
    a_full_excl_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && (m_tdata == '0))
        else $error("full result carries hit data");

    // The sequencer never offers a result while it can take a request.
    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !seq_res_valid)
        else $error("sequencer idle with a pending result");

    // A new output only appears after the sequencer offered one.
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(seq_res_valid))
        else $error("output raised without a sequencer result");
`endif

endmodule

// File: verif/tb_fully_associative_tlb.sv
// Self-checking testbench for fully_associative_tlb: directed requests, then random
// fill / mixed phases with a request-level shadow TLB for the expected results.
// Depends on fatlb_pkg and the RTL under hdl/.
module tb_fully_associative_tlb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1730;
    localparam int FULL_EXTRA      = 40;    // requests kept going once the table is full
    localparam int MIXED_LEN       = 200;
    // Worst request is a full scan plus short random stalls on either side.
    localparam int QUIET_LIMIT     = 3000;

    typedef struct {
        fatlb_pkg::req_e_t                kind;
        logic [fatlb_pkg::PAGE_BITS-1:0]  page;
        logic [fatlb_pkg::FRAME_BITS-1:0] frame;
        bit                               typed;   // want holds the answer read off by hand
        fatlb_pkg::res_t                  want;
    } directed_step_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [fatlb_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [fatlb_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fatlb_pkg::M_TDATA_W-1:0] m_tdata;
    logic [fatlb_pkg::M_TUSER_W-1:0] m_tuser;

    // Side-band for directed rows: travels with s_tdata so the scoreboard samples it
    // at the same edge the request is accepted.
    bit              use_typed    = 1'b0;
    fatlb_pkg::res_t typed_result = '0;

    // Shadow copy of the TLB contents.
    bit                               tlb_valid [fatlb_pkg::ENTRIES];
    bit [fatlb_pkg::PAGE_BITS-1:0]    tlb_page  [fatlb_pkg::ENTRIES];
    bit [fatlb_pkg::FRAME_BITS-1:0]   tlb_frame [fatlb_pkg::ENTRIES];

    fatlb_pkg::res_t pending_results[$];
    directed_step_t  directed_steps[$];
    int              mismatches   = 0;
    int              quiet_cycles = 0;
    int              idle_pct     = 12;

    fully_associative_tlb dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // page_number[7:0], frame_number[14:8], pad
        .s_tuser  (s_tuser),   // req_type[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // found_frame[6:0], pad
        .m_tuser  (m_tuser)    // hit[0], full_res[1]
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow TLB: applies one request and returns the result the block must give.
    // Every scan takes the lowest-numbered qualifying entry.
    function automatic fatlb_pkg::res_t tlb_apply(input fatlb_pkg::req_t rq);
        fatlb_pkg::res_t r;
        bit              done;
        r    = '0;
        done = 1'b0;
        case (rq.req_type)
            fatlb_pkg::REQ_LOOKUP: begin
                for (int i = 0; i < fatlb_pkg::ENTRIES && !done; i++) begin
                    if (tlb_valid[i] && tlb_page[i] == rq.page_number) begin
                        r.hit         = 1'b1;
                        r.found_frame = tlb_frame[i];
                        done          = 1'b1;
                    end
                end
            end
            fatlb_pkg::REQ_INSERT: begin
                // No duplicate check: a page already present still gets a new entry.
                r.full_res = 1'b1;
                for (int i = 0; i < fatlb_pkg::ENTRIES && !done; i++) begin
                    if (!tlb_valid[i]) begin
                        tlb_valid[i] = 1'b1;
                        tlb_page[i]  = rq.page_number;
                        tlb_frame[i] = rq.frame_number;
                        r.full_res   = 1'b0;
                        done         = 1'b1;
                    end
                end
            end
            fatlb_pkg::REQ_INVAL: begin
                // Only valid entries are compared; the first one holding the frame goes.
                for (int i = 0; i < fatlb_pkg::ENTRIES && !done; i++) begin
                    if (tlb_valid[i] && tlb_frame[i] == rq.frame_number) begin
                        tlb_valid[i] = 1'b0;
                        tlb_page[i]  = '0;
                        tlb_frame[i] = '0;
                        done         = 1'b1;
                    end
                end
            end
            default: begin
                foreach (tlb_valid[i]) begin
                    tlb_valid[i] = 1'b0;
                    tlb_page[i]  = '0;
                    tlb_frame[i] = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic int valid_count();
        int live;
        live = 0;
        foreach (tlb_valid[i]) begin
            if (tlb_valid[i]) live++;
        end
        return live;
    endfunction

    // Index of a random live entry, or -1 when the table is empty.
    function automatic int pick_valid();
        int k;
        int live;
        live = valid_count();
        if (live == 0) return -1;
        k = $urandom_range(0, live - 1);
        foreach (tlb_valid[i]) begin
            if (tlb_valid[i]) begin
                if (k == 0) return i;
                k--;
            end
        end
        return -1;
    endfunction

    // Random request. Most lookups and invalidates aim at live entries so they hit;
    // the rest are misses on random pages or frames. Filling mode is insert-heavy and
    // never flushes, so the table reaches full.
    function automatic fatlb_pkg::req_t random_request(input bit filling);
        fatlb_pkg::req_t rq;
        int              roll;
        int              idx;
        roll            = $urandom_range(0, 99);
        idx             = pick_valid();
        rq.page_number  = fatlb_pkg::PAGE_BITS'(
                              $urandom_range(0, (1 << fatlb_pkg::PAGE_BITS) - 1));
        rq.frame_number = fatlb_pkg::FRAME_BITS'(
                              $urandom_range(0, (1 << fatlb_pkg::FRAME_BITS) - 1));
        if (roll < (filling ? 70 : 30)) begin
            rq.req_type = fatlb_pkg::REQ_INSERT;
            if (idx >= 0 && $urandom_range(0, 99) < 15) rq.page_number = tlb_page[idx];
        end else if (roll < (filling ? 90 : 70)) begin
            rq.req_type = fatlb_pkg::REQ_LOOKUP;
            if (idx >= 0 && $urandom_range(0, 99) < 75) rq.page_number = tlb_page[idx];
        end else if (filling || roll < 97) begin
            rq.req_type = fatlb_pkg::REQ_INVAL;
            if (idx >= 0 && $urandom_range(0, 99) < 70) rq.frame_number = tlb_frame[idx];
        end else begin
            rq.req_type = fatlb_pkg::REQ_FLUSH;
        end
        return rq;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Scoreboard, watchdog and result-side backpressure. The result is checked before
    // the new request is predicted, so a request and a result in the same edge are fine.
    always @(posedge aclk) begin
        fatlb_pkg::res_t got;
        fatlb_pkg::res_t want;
        fatlb_pkg::req_t rq;
        fatlb_pkg::res_t predicted;
        if (m_tvalid && m_tready) begin
            got.hit         = m_tuser[0];
            got.full_res    = m_tuser[1];
            got.found_frame = m_tdata[fatlb_pkg::FRAME_BITS-1:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, %s hit=%0b frame=%0d full=%0b",
                         $time, "actual", got.hit, got.found_frame, got.full_res);
            end else begin
                want = pending_results.pop_front();
                check_field("hit", int'(want.hit), int'(got.hit));
                check_field("found_frame", int'(want.found_frame), int'(got.found_frame));
                check_field("full_res", int'(want.full_res), int'(got.full_res));
            end
        end
        if (s_tvalid && s_tready) begin
            rq.req_type     = fatlb_pkg::req_e_t'(s_tuser);
            rq.page_number  = s_tdata[fatlb_pkg::PAGE_BITS-1:0];
            rq.frame_number = s_tdata[fatlb_pkg::PAGE_BITS +: fatlb_pkg::FRAME_BITS];
            predicted       = tlb_apply(rq);
            pending_results.push_back(use_typed ? typed_result : predicted);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= idle_pct);
    end

    // Present one request and hold it until accepted. s_tvalid stays high into the
    // next request unless an idle gap is drawn, so it is never dropped and raised in
    // one step.
    task automatic send_request(input fatlb_pkg::req_t rq, input bit typed,
                                input fatlb_pkg::res_t want);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= fatlb_pkg::S_TDATA_W'({rq.frame_number, rq.page_number});
        s_tuser      <= rq.req_type;
        use_typed    <= typed;
        typed_result <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Sender goes quiet until every outstanding result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic add_step(input fatlb_pkg::req_e_t kind, input int page, input int frame,
                            input bit typed, input bit hit, input int ff, input bit full);
        directed_step_t st;
        st.kind             = kind;
        st.page             = fatlb_pkg::PAGE_BITS'(page);
        st.frame            = fatlb_pkg::FRAME_BITS'(frame);
        st.typed            = typed;
        st.want.hit         = hit;
        st.want.found_frame = fatlb_pkg::FRAME_BITS'(ff);
        st.want.full_res    = full;
        directed_steps.push_back(st);
    endtask

    initial begin
        fatlb_pkg::req_t rq;
        int              sent;
        int              extra;
        bit              first_round;

        // Empty table: misses and a no-op invalidate.
        add_step(fatlb_pkg::REQ_LOOKUP, 0,     0,     1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 255,   0,     1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_INVAL,  0,     0,     1, 0, 0,   0);
        // Extremes of page and frame round trip.
        add_step(fatlb_pkg::REQ_INSERT, 255,   127,   1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 255,   0,     1, 1, 127, 0);
        add_step(fatlb_pkg::REQ_INSERT, 0,     0,     1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 0,     0,     1, 1, 0,   0);
        // Duplicate page: lowest entry wins until it is invalidated.
        add_step(fatlb_pkg::REQ_INSERT, 255,   5,     1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 255,   0,     1, 1, 127, 0);
        add_step(fatlb_pkg::REQ_INVAL,  0,     127,   1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 255,   0,     0, 0, 0,   0);
        add_step(fatlb_pkg::REQ_INVAL,  0,     99,    1, 0, 0,   0);
        // Two entries share a frame: invalidate takes only the first.
        add_step(fatlb_pkg::REQ_INSERT, 1,     9,     0, 0, 0,   0);
        add_step(fatlb_pkg::REQ_INSERT, 2,     9,     0, 0, 0,   0);
        add_step(fatlb_pkg::REQ_INVAL,  0,     9,     0, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 1,     0,     0, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 2,     0,     0, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 8'h5A, 0,     0, 0, 0,   0);
        // Flush drops everything.
        add_step(fatlb_pkg::REQ_FLUSH,  255,   127,   1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 0,     0,     1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 2,     0,     1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_INVAL,  0,     9,     1, 0, 0,   0);
        add_step(fatlb_pkg::REQ_INSERT, 8'hAA, 7'h55, 0, 0, 0,   0);
        add_step(fatlb_pkg::REQ_LOOKUP, 8'hAA, 0,     0, 0, 0,   0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            rq.req_type     = directed_steps[i].kind;
            rq.page_number  = directed_steps[i].page;
            rq.frame_number = directed_steps[i].frame;
            send_request(rq, directed_steps[i].typed, directed_steps[i].want);
        end
        drain();

        // Rounds of fill-until-full (plus inserts that must bounce) and a mixed phase.
        // The first fill runs with no idling on either side.
        sent        = 0;
        first_round = 1'b1;
        while (sent < RANDOM_REQUESTS) begin
            idle_pct = first_round ? 0 : 12;
            extra    = 0;
            while (sent < RANDOM_REQUESTS && extra < FULL_EXTRA) begin
                send_request(random_request(1'b1), 1'b0, '0);
                sent++;
                if (valid_count() == fatlb_pkg::ENTRIES) extra++;
            end
            idle_pct    = 12;
            first_round = 1'b0;
            drain();
            for (int n = 0; n < MIXED_LEN && sent < RANDOM_REQUESTS; n++) begin
                send_request(random_request(1'b0), 1'b0, '0);
                sent++;
            end
        end

        drain();
        repeat (fatlb_pkg::ENTRIES + 8) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
